// ----- design/imc_pkg.sv -----
package imc_pkg;

  // Controller modes.
  typedef enum logic [2:0] {
    MODE_BOOT    = 3'd0,
    MODE_INIT    = 3'd1,
    MODE_IDLE    = 3'd2,
    MODE_RUNNING = 3'd3,
    MODE_RAIN    = 3'd4,
    MODE_FAULT   = 3'd5,
    MODE_ESTOP   = 3'd6
  } mode_t;

  // Event codes; codes above emergency clear are unused and rejected.
  typedef enum logic [3:0] {
    EV_BOOT_DONE   = 4'd0,
    EV_INIT_DONE   = 4'd1,
    EV_START       = 4'd2,
    EV_STOP        = 4'd3,
    EV_RAIN_SET    = 4'd4,
    EV_RAIN_CLEAR  = 4'd5,
    EV_FAULT       = 4'd6,
    EV_FAULT_CLEAR = 4'd7,
    EV_ESTOP       = 4'd8,
    EV_ESTOP_CLEAR = 4'd9
  } event_t;

  // Zone value that means no zone is active.
  localparam logic signed [7:0] NO_ZONE = -8'sd1;

  // Controller status kept between items.
  typedef struct packed {
    mode_t             mode;
    logic              valve;
    logic signed [7:0] zone;
    logic              estop;
  } status_t;

endpackage

// ----- design/imc_step.sv -----
module imc_step
  import imc_pkg::*;
(
  input  status_t     cur,
  input  logic [3:0]  operation,
  input  logic [6:0]  zone_number,
  output status_t     nxt,
  output logic        accepted
);

  event_t ev;

  assign ev = event_t'(operation);

  // One guarded update of the status for the current event.
  always_comb begin
    nxt      = cur;
    accepted = 1'b0;
    if (!cur.estop || ev == EV_ESTOP_CLEAR) begin
      unique case (ev)
        EV_BOOT_DONE: begin
          if (cur.mode == MODE_BOOT) begin
            nxt.mode = MODE_INIT;
            accepted = 1'b1;
          end
        end
        EV_INIT_DONE: begin
          if (cur.mode == MODE_INIT) begin
            nxt.mode = MODE_IDLE;
            accepted = 1'b1;
          end
        end
        EV_START: begin
          if (cur.mode == MODE_IDLE || cur.mode == MODE_RUNNING) begin
            nxt.mode  = MODE_RUNNING;
            nxt.valve = 1'b1;
            nxt.zone  = signed'({1'b0, zone_number});
            accepted  = 1'b1;
          end
        end
        EV_STOP: begin
          if (cur.mode == MODE_RUNNING) begin
            nxt.mode  = MODE_IDLE;
            nxt.valve = 1'b0;
            nxt.zone  = NO_ZONE;
            accepted  = 1'b1;
          end
        end
        EV_RAIN_SET: begin
          if (cur.mode == MODE_IDLE || cur.mode == MODE_RUNNING) begin
            nxt.mode  = MODE_RAIN;
            nxt.valve = 1'b0;
            nxt.zone  = NO_ZONE;
            accepted  = 1'b1;
          end
        end
        EV_RAIN_CLEAR: begin
          if (cur.mode == MODE_RAIN) begin
            nxt.mode = MODE_IDLE;
            accepted = 1'b1;
          end
        end
        EV_FAULT: begin
          nxt.mode  = MODE_FAULT;
          nxt.valve = 1'b0;
          nxt.zone  = NO_ZONE;
          accepted  = 1'b1;
        end
        EV_FAULT_CLEAR: begin
          if (cur.mode == MODE_FAULT) begin
            nxt.mode = MODE_IDLE;
            accepted = 1'b1;
          end
        end
        EV_ESTOP: begin
          nxt.mode  = MODE_ESTOP;
          nxt.valve = 1'b0;
          nxt.zone  = NO_ZONE;
          nxt.estop = 1'b1;
          accepted  = 1'b1;
        end
        EV_ESTOP_CLEAR: begin
          if (cur.mode == MODE_ESTOP) begin
            nxt.mode  = MODE_IDLE;
            nxt.estop = 1'b0;
            accepted  = 1'b1;
          end
        end
        default: begin
          accepted = 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- design/irrigation_mode_controller.sv -----
// Irrigation mode controller.
//
// The event channel (event_valid, event_ready, operation, zone_number) takes
// one event item per cycle unless stalled. Each event yields exactly one
// result item on the result channel (result_valid, result_ready, accepted,
// mode, master_valve, running_zone, estop_latched): the accepted flag and
// the status after the event. A rejected event leaves the status unchanged.
//
// An item passes an input register and then a result register, so its
// result is registered; a stalled receiver can hold it in either register.
// The status update is one pass of the event decoder in imc_step, so one
// item per cycle is sustained while the receiver takes results.
//
// When the receiver stalls, the result register holds and the input
// register can still take one more item; after that event_ready drops
// until the result is taken.
//
// Reset (rst, synchronous) empties both registers and sets boot mode,
// valve closed, no running zone and the emergency latch clear.
module irrigation_mode_controller
  import imc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              event_valid,
  output logic              event_ready,
  input  logic [3:0]        operation,
  input  logic [6:0]        zone_number,
  output logic              result_valid,
  input  logic              result_ready,
  output logic              accepted,
  output logic [2:0]        mode,
  output logic              master_valve,
  output logic signed [7:0] running_zone,
  output logic              estop_latched
);

  // Input register.
  logic       in_full;
  logic [3:0] op_q;
  logic [6:0] zone_q;

  // Controller status and result register.
  status_t status;
  status_t status_next;
  status_t res_status;
  logic    res_accepted;
  logic    step_accepted;
  logic    advance;

  // The held item moves on when the result register is free or being taken.
  assign advance     = in_full && (!result_valid || result_ready);
  assign event_ready = !in_full || advance;

  imc_step u_step (
    .cur         (status),
    .operation   (op_q),
    .zone_number (zone_q),
    .nxt         (status_next),
    .accepted    (step_accepted)
  );

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (event_ready) begin
      in_full <= event_valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (event_valid && event_ready) begin
      op_q   <= operation;
      zone_q <= zone_number;
    end
  end

  // Status update, one event per advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      status.mode  <= MODE_BOOT;
      status.valve <= 1'b0;
      status.zone  <= NO_ZONE;
      status.estop <= 1'b0;
    end else if (advance) begin
      status <= status_next;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      res_status   <= status_next;
      res_accepted <= step_accepted;
    end
  end

  assign accepted      = res_accepted;
  assign mode          = res_status.mode;
  assign master_valve  = res_status.valve;
  assign running_zone  = res_status.zone;
  assign estop_latched = res_status.estop;

  // The emergency latch is only ever set together with emergency-stop mode.
  a_estop_mode: assert property (@(posedge clk) disable iff (rst)
    status.estop |-> status.mode == MODE_ESTOP)
    else $error("emergency latch set outside emergency-stop mode");

  // The master valve is open exactly while a zone runs.
  a_valve_running: assert property (@(posedge clk) disable iff (rst)
    status.valve == (status.mode == MODE_RUNNING))
    else $error("master valve disagrees with running mode");

  // A zone is active exactly while the valve is open.
  a_zone_valve: assert property (@(posedge clk) disable iff (rst)
    (status.zone != NO_ZONE) == status.valve)
    else $error("active zone disagrees with master valve");

  // A rejected event leaves the status untouched.
  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    advance && !step_accepted |=> $stable(status))
    else $error("rejected event changed the status");

endmodule

// ----- tb/tb_irrigation_mode_controller.sv -----
`timescale 1ns / 100ps

module tb_irrigation_mode_controller;
  import imc_pkg::*;

  // Status reported with each event, as the checker compares it.
  typedef struct packed {
    logic              accepted;
    mode_t             mode;
    logic              valve;
    logic signed [7:0] zone;
    logic              latch;
  } ctrl_report_t;

  // One directed event; a typed-in report is used where fixed is set.
  typedef struct packed {
    logic [3:0]   op;
    logic [6:0]   zn;
    logic         fixed;
    ctrl_report_t want;
  } stim_row_t;

  localparam logic [3:0] EV_UNUSED_LO = 4'd10;
  localparam logic [3:0] EV_UNUSED_HI = 4'd15;
  localparam ctrl_report_t REPORT_PREDICTED = '0;
  localparam int DIRECTED_COUNT = 25;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int PHASE_COUNT = 4;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              event_valid = 1'b0;
  logic              event_ready;
  logic [3:0]        operation = '0;
  logic [6:0]        zone_number = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic              accepted;
  logic [2:0]        mode;
  logic              master_valve;
  logic signed [7:0] running_zone;
  logic              estop_latched;

  int idle_pct = 0;
  int stall_pct = 0;
  bit failed = 1'b0;

  // Controller status as the testbench expects it, and reports in flight.
  status_t      ctrl_status;
  ctrl_report_t expected_reports[$];

  // Idling of the sender and stalling of the receiver, per phase.
  int phase_idle[PHASE_COUNT]  = '{0, 72, 0, 30};
  int phase_stall[PHASE_COUNT] = '{0, 0, 72, 30};

  // Directed events: early rejects after reset, the mode walk, zone extremes
  // and the emergency latch blocking everything but emergency clear.
  stim_row_t directed_rows[DIRECTED_COUNT] = '{
    '{EV_INIT_DONE,   7'd0,   1'b1, '{1'b0, MODE_BOOT, 1'b0, NO_ZONE, 1'b0}},
    '{EV_START,       7'd5,   1'b1, '{1'b0, MODE_BOOT, 1'b0, NO_ZONE, 1'b0}},
    '{EV_UNUSED_HI,   7'd127, 1'b1, '{1'b0, MODE_BOOT, 1'b0, NO_ZONE, 1'b0}},
    '{EV_BOOT_DONE,   7'd0,   1'b0, REPORT_PREDICTED},
    '{EV_INIT_DONE,   7'd0,   1'b0, REPORT_PREDICTED},
    '{EV_STOP,        7'd0,   1'b0, REPORT_PREDICTED},
    '{EV_START,       7'd0,   1'b1, '{1'b1, MODE_RUNNING, 1'b1, 8'sd0, 1'b0}},
    '{EV_START,       7'd127, 1'b1, '{1'b1, MODE_RUNNING, 1'b1, 8'sd127, 1'b0}},
    '{EV_RAIN_CLEAR,  7'd0,   1'b0, REPORT_PREDICTED},
    '{EV_STOP,        7'd0,   1'b0, REPORT_PREDICTED},
    '{EV_START,       7'd85,  1'b0, REPORT_PREDICTED},
    '{EV_RAIN_SET,    7'd0,   1'b0, REPORT_PREDICTED},
    '{EV_START,       7'd9,   1'b0, REPORT_PREDICTED},
    '{EV_RAIN_CLEAR,  7'd0,   1'b0, REPORT_PREDICTED},
    '{EV_FAULT_CLEAR, 7'd0,   1'b0, REPORT_PREDICTED},
    '{EV_START,       7'd42,  1'b0, REPORT_PREDICTED},
    '{EV_FAULT,       7'd0,   1'b0, REPORT_PREDICTED},
    '{EV_FAULT_CLEAR, 7'd0,   1'b0, REPORT_PREDICTED},
    '{EV_ESTOP_CLEAR, 7'd0,   1'b0, REPORT_PREDICTED},
    '{EV_START,       7'd1,   1'b0, REPORT_PREDICTED},
    '{EV_ESTOP,       7'd0,   1'b1, '{1'b1, MODE_ESTOP, 1'b0, NO_ZONE, 1'b1}},
    '{EV_FAULT,       7'd0,   1'b1, '{1'b0, MODE_ESTOP, 1'b0, NO_ZONE, 1'b1}},
    '{EV_ESTOP,       7'd0,   1'b1, '{1'b0, MODE_ESTOP, 1'b0, NO_ZONE, 1'b1}},
    '{EV_UNUSED_LO,   7'd3,   1'b1, '{1'b0, MODE_ESTOP, 1'b0, NO_ZONE, 1'b1}},
    '{EV_ESTOP_CLEAR, 7'd0,   1'b1, '{1'b1, MODE_IDLE, 1'b0, NO_ZONE, 1'b0}}
  };

  irrigation_mode_controller DUT (
    .clk          (clk),
    .rst          (rst),
    .event_valid  (event_valid),
    .event_ready  (event_ready),
    .operation    (operation),
    .zone_number  (zone_number),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .accepted     (accepted),
    .mode         (mode),
    .master_valve (master_valve),
    .running_zone (running_zone),
    .estop_latched(estop_latched)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one event to the expected status and return the report for it.
  // A rejected event leaves the status as it was.
  function automatic ctrl_report_t advance_controller(logic [3:0] op, logic [6:0] zn);
    status_t nxt;
    logic    ok;
    nxt = ctrl_status;
    ok  = 1'b0;
    if (!ctrl_status.estop || op == EV_ESTOP_CLEAR) begin
      case (op)
        EV_BOOT_DONE: if (nxt.mode == MODE_BOOT) begin
          nxt.mode = MODE_INIT;
          ok = 1'b1;
        end
        EV_INIT_DONE: if (nxt.mode == MODE_INIT) begin
          nxt.mode = MODE_IDLE;
          ok = 1'b1;
        end
        EV_START: if (nxt.mode == MODE_IDLE || nxt.mode == MODE_RUNNING) begin
          nxt.mode  = MODE_RUNNING;
          nxt.valve = 1'b1;
          nxt.zone  = {1'b0, zn};
          ok = 1'b1;
        end
        EV_STOP: if (nxt.mode == MODE_RUNNING) begin
          nxt.mode  = MODE_IDLE;
          nxt.valve = 1'b0;
          nxt.zone  = NO_ZONE;
          ok = 1'b1;
        end
        EV_RAIN_SET: if (nxt.mode == MODE_IDLE || nxt.mode == MODE_RUNNING) begin
          nxt.mode  = MODE_RAIN;
          nxt.valve = 1'b0;
          nxt.zone  = NO_ZONE;
          ok = 1'b1;
        end
        EV_RAIN_CLEAR: if (nxt.mode == MODE_RAIN) begin
          nxt.mode = MODE_IDLE;
          ok = 1'b1;
        end
        EV_FAULT: begin
          nxt.mode  = MODE_FAULT;
          nxt.valve = 1'b0;
          nxt.zone  = NO_ZONE;
          ok = 1'b1;
        end
        EV_FAULT_CLEAR: if (nxt.mode == MODE_FAULT) begin
          nxt.mode = MODE_IDLE;
          ok = 1'b1;
        end
        EV_ESTOP: begin
          nxt.mode  = MODE_ESTOP;
          nxt.valve = 1'b0;
          nxt.zone  = NO_ZONE;
          nxt.estop = 1'b1;
          ok = 1'b1;
        end
        EV_ESTOP_CLEAR: if (nxt.mode == MODE_ESTOP) begin
          nxt.mode  = MODE_IDLE;
          nxt.estop = 1'b0;
          ok = 1'b1;
        end
        default: ;
      endcase
    end
    if (ok) ctrl_status = nxt;
    return '{ok, ctrl_status.mode, ctrl_status.valve, ctrl_status.zone, ctrl_status.estop};
  endfunction

  // Mostly events that are legal in the current mode, so that the run keeps
  // moving through all modes; the rest is any code, unused ones included.
  function automatic logic [3:0] pick_event();
    int r;
    r = $urandom_range(9);
    if ($urandom_range(99) < 25) return 4'($urandom_range(15));
    if (ctrl_status.estop) return EV_ESTOP_CLEAR;
    case (ctrl_status.mode)
      MODE_BOOT: return EV_BOOT_DONE;
      MODE_INIT: return EV_INIT_DONE;
      MODE_IDLE, MODE_RUNNING: begin
        if (r < 4) return EV_START;
        if (r < 6) return EV_STOP;
        if (r < 8) return EV_RAIN_SET;
        if (r < 9) return EV_FAULT;
        return EV_ESTOP;
      end
      MODE_RAIN: begin
        if (r < 7) return EV_RAIN_CLEAR;
        if (r < 9) return EV_FAULT;
        return EV_ESTOP;
      end
      MODE_FAULT: begin
        if (r < 7) return EV_FAULT_CLEAR;
        if (r < 9) return EV_FAULT;
        return EV_ESTOP;
      end
      default: return EV_ESTOP_CLEAR;
    endcase
  endfunction

  // Zone numbers lean toward both ends of the range.
  function automatic logic [6:0] pick_zone();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'd127;
    return 7'($urandom_range(127));
  endfunction

  // Present one event item, hold it until taken, then record its report.
  task automatic send_event(input stim_row_t row);
    ctrl_report_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      event_valid <= 1'b0;
      @(posedge clk);
    end
    event_valid <= 1'b1;
    operation   <= row.op;
    zone_number <= row.zn;
    @(posedge clk);
    while (!event_ready) @(posedge clk);
    predicted = advance_controller(row.op, row.zn);
    expected_reports.push_back(row.fixed ? row.want : predicted);
  endtask

  // Receiver: stall at random according to the current phase.
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check each result item against the oldest expected report.
  always @(posedge clk) begin
    ctrl_report_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_reports.size() == 0) begin
        $error("result item with no event pending");
        failed = 1'b1;
      end else begin
        want = expected_reports.pop_front();
        if (accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, accepted);
          failed = 1'b1;
        end
        if (mode !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, mode);
          failed = 1'b1;
        end
        if (master_valve !== want.valve) begin
          $error("master_valve: expected %0d, got %0d", want.valve, master_valve);
          failed = 1'b1;
        end
        if (running_zone !== want.zone) begin
          $error("running_zone: expected %0d, got %0d", want.zone, running_zone);
          failed = 1'b1;
        end
        if (estop_latched !== want.latch) begin
          $error("estop_latched: expected %0d, got %0d", want.latch, estop_latched);
          failed = 1'b1;
        end
      end
    end
  end

  // Reset, directed events, then random events over the idling and stalling phases.
  initial begin
    stim_row_t row;
    ctrl_status = '{MODE_BOOT, 1'b0, NO_ZONE, 1'b0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_event(directed_rows[i]);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        row.op    = pick_event();
        row.zn    = pick_zone();
        row.fixed = 1'b0;
        row.want  = REPORT_PREDICTED;
        send_event(row);
      end
    end

    // Drain the results still in flight, then allow the pipeline to settle.
    event_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (!failed) begin
      $display("tb_irrigation_mode_controller: done, clean");
    end else begin
      $display("tb_irrigation_mode_controller: done, errors");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #2_000_000;
    $display("tb_irrigation_mode_controller: done, errors");
    $finish;
  end

endmodule
